@@ rtl/mmas_pkg.sv @@
package mmas_pkg;

    // Field and datapath widths.
    localparam int SampleW  = 12;
    localparam int SumW     = 16;
    localparam int CfgW     = 16;
    localparam int DiffW    = CfgW + 1;
    localparam int ProdW    = SampleW + 1 + DiffW - 1;
    localparam int ScaleW   = 2 * SampleW + 6;
    localparam int NumW     = 32;
    localparam int MagW     = NumW - 1;
    localparam int QuotW    = 20;
    localparam int CfgIdxW  = 3;

    // Number of channels the register map always holds.
    localparam int NumCfgCh = 2;

    // Full-scale raw code that maps onto out_max.
    localparam int FullScale = 4095;

    // Saturation limits of the signed Q8.8 result.
    localparam logic signed [CfgW-1:0] SatMax = 16'sh7fff;
    localparam logic signed [CfgW-1:0] SatMin = 16'sh8000;

    // Reset values of the per-channel registers.
    localparam logic signed [CfgW-1:0] RstOutMin = 16'sd0;
    localparam logic signed [CfgW-1:0] RstOutMax = 16'sd25600;
    localparam logic signed [CfgW-1:0] RstOffset = 16'sd0;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_CH0_OUT_MIN = 3'd0,
        CFG_CH0_OUT_MAX = 3'd1,
        CFG_CH0_OFFSET  = 3'd2,
        CFG_CH1_OUT_MIN = 3'd3,
        CFG_CH1_OUT_MAX = 3'd4,
        CFG_CH1_OFFSET  = 3'd5
    } t_cfg_idx;

    // Scaling registers of one channel.
    typedef struct packed {
        logic signed [CfgW-1:0] out_min;
        logic signed [CfgW-1:0] out_max;
        logic signed [CfgW-1:0] offset;
    } t_ch_cfg;

    // Item handed from the window stage to the scaling pipeline.
    typedef struct packed {
        logic                    ch;
        logic [SumW-1:0]         sum;
        logic signed [DiffW-1:0] diff;
        logic signed [DiffW-1:0] base;
    } t_win_item;

endpackage

@@ rtl/mmas_cfg.sv @@
module mmas_cfg (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [mmas_pkg::CfgIdxW-1:0]               i_cfg_index,
    input  logic [mmas_pkg::CfgW-1:0]                  i_cfg_data,
    output mmas_pkg::t_ch_cfg [mmas_pkg::NumCfgCh-1:0] o_ch_cfg
);
    import mmas_pkg::*;

    t_ch_cfg [NumCfgCh-1:0] r_ch_cfg;
    t_ch_cfg [NumCfgCh-1:0] n_ch_cfg;

    // A write is taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // Decode the register index; indexes beyond the map are dropped.
    always_comb begin
        n_ch_cfg = r_ch_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CH0_OUT_MIN: n_ch_cfg[0].out_min = i_cfg_data;
                CFG_CH0_OUT_MAX: n_ch_cfg[0].out_max = i_cfg_data;
                CFG_CH0_OFFSET:  n_ch_cfg[0].offset  = i_cfg_data;
                CFG_CH1_OUT_MIN: n_ch_cfg[1].out_min = i_cfg_data;
                CFG_CH1_OUT_MAX: n_ch_cfg[1].out_max = i_cfg_data;
                CFG_CH1_OFFSET:  n_ch_cfg[1].offset  = i_cfg_data;
                default:         n_ch_cfg = r_ch_cfg;
            endcase
        end
    end

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NumCfgCh; c++) begin
                r_ch_cfg[c].out_min <= RstOutMin;
                r_ch_cfg[c].out_max <= RstOutMax;
                r_ch_cfg[c].offset  <= RstOffset;
            end
        end else begin
            r_ch_cfg <= n_ch_cfg;
        end
    end

    assign o_ch_cfg = r_ch_cfg;

endmodule

@@ rtl/mmas_window.sv @@
module mmas_window #(
    parameter int CHANNELS  = 2,
    parameter int AVG_DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic                                       i_channel,
    input  logic [mmas_pkg::SampleW-1:0]               i_raw_sample,
    input  mmas_pkg::t_ch_cfg [mmas_pkg::NumCfgCh-1:0] i_ch_cfg,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output mmas_pkg::t_win_item                        o_item
);
    import mmas_pkg::*;

    localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SampleW-1:0] r_hist [CHANNELS][AVG_DEPTH];
    logic [SumW-1:0]    r_sum  [CHANNELS];
    logic               r_valid;
    t_win_item          r_item;
    t_win_item          n_item;
    logic [SumW-1:0]    n_sum;
    logic               w_ch;
    logic [ChIdxW-1:0]  w_idx;
    logic               w_accept;
    t_ch_cfg            w_cfg;

    // Channels beyond the configured count fold onto the last one.
    assign w_ch  = (CHANNELS < 2) ? 1'b0 : i_channel;
    assign w_idx = ChIdxW'(w_ch);

    // The stage register loads when empty or when it is drained.
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Running sum: add the new sample, drop the one leaving the window.
    assign n_sum = r_sum[w_idx] + SumW'(i_raw_sample) - SumW'(r_hist[w_idx][AVG_DEPTH-1]);

    // Slope and intercept terms of the channel's linear map.
    always_comb begin
        w_cfg       = i_ch_cfg[w_ch];
        n_item.ch   = w_ch;
        n_item.sum  = n_sum;
        n_item.diff = {w_cfg.out_max[CfgW-1], w_cfg.out_max}
                    - {w_cfg.out_min[CfgW-1], w_cfg.out_min};
        n_item.base = {w_cfg.out_min[CfgW-1], w_cfg.out_min}
                    + {w_cfg.offset[CfgW-1], w_cfg.offset};
    end

    // Sample history, window sums and stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int j = 0; j < AVG_DEPTH; j++) begin
                    r_hist[c][j] <= '0;
                end
                r_sum[c] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                for (int j = AVG_DEPTH - 1; j > 0; j--) begin
                    r_hist[w_idx][j] <= r_hist[w_idx][j-1];
                end
                r_hist[w_idx][0] <= i_raw_sample;
                r_sum[w_idx]     <= n_sum;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

`ifndef SYNTHESIS
    // An accepted sample lands at the head of its channel's history.
    a_hist_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_hist[$past(w_idx)][0] == $past(i_raw_sample)))
        else $error("sample not written at the head of the history");

    // A held stage keeps its item while downstream is stalled.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_item)))
        else $error("window stage lost or changed a stalled transaction");

    // Reset clears channel 0's running sum.
    a_sum_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_sum[0] == '0))
        else $error("window sum not cleared by reset");
`endif

endmodule

@@ rtl/mmas_scale.sv @@
module mmas_scale #(
    parameter int AVG_DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  mmas_pkg::t_win_item                     i_item,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_out_channel,
    output logic [mmas_pkg::SampleW-1:0]            o_average_raw,
    output logic signed [mmas_pkg::CfgW-1:0]        o_scaled_value
);
    import mmas_pkg::*;

    // Exact reciprocal for dividing a SumW-bit sum by AVG_DEPTH.
    localparam int DivShift = SumW + $clog2(AVG_DEPTH);
    localparam int DivProdW = SumW + DivShift + 1;
    localparam logic [DivShift:0] DivMul =
        (DivShift+1)'(((64'd1 << DivShift) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    localparam int NumStages = 6;

    // Stage valids and load enables, stage 0 first, output stage last.
    logic [NumStages-1:0] r_valid;
    logic [NumStages-1:0] w_en;

    // Stage 0: average, slope, scaled intercept.
    logic                     r0_ch;
    logic [SampleW-1:0]       r0_avg;
    logic signed [DiffW-1:0]  r0_diff;
    logic signed [ScaleW-1:0] r0_base;
    // Stage 1: numerator.
    logic                     r1_ch;
    logic [SampleW-1:0]       r1_avg;
    logic signed [NumW-1:0]   r1_num;
    // Stage 2: sign and magnitude.
    logic                     r2_ch;
    logic [SampleW-1:0]       r2_avg;
    logic                     r2_neg;
    logic [MagW-1:0]          r2_mag;
    // Stage 3: quotient estimate.
    logic                     r3_ch;
    logic [SampleW-1:0]       r3_avg;
    logic                     r3_neg;
    logic [MagW-1:0]          r3_mag;
    logic [QuotW-1:0]         r3_qe;
    // Stage 4: corrected quotient magnitude.
    logic                     r4_ch;
    logic [SampleW-1:0]       r4_avg;
    logic                     r4_neg;
    logic [QuotW-1:0]         r4_q;
    // Output stage.
    logic                     r5_ch;
    logic [SampleW-1:0]       r5_avg;
    logic signed [CfgW-1:0]   r5_val;

    logic [DivProdW-1:0]      w_avg_prod;
    logic signed [ScaleW-1:0] w_base_ext;
    logic signed [ProdW-1:0]  w_prod;
    logic signed [NumW-1:0]   w_num;
    logic [MagW-1:0]          w_mag;
    logic [NumW-1:0]          w_est;
    logic signed [NumW-1:0]   w_rem;
    logic [QuotW-1:0]         w_q;
    logic signed [CfgW-1:0]   w_val;

    // Each stage loads when empty or when the next one loads.
    always_comb begin
        w_en[NumStages-1] = !r_valid[NumStages-1] || i_ready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Window average by reciprocal multiply; intercept times full scale by shift.
    assign w_avg_prod = DivProdW'(i_item.sum) * DivProdW'(DivMul);
    assign w_base_ext = {{(ScaleW-DiffW){i_item.base[DiffW-1]}}, i_item.base};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_ch   <= i_item.ch;
            r0_avg  <= SampleW'(w_avg_prod >> DivShift);
            r0_diff <= i_item.diff;
            r0_base <= (w_base_ext <<< SampleW) - w_base_ext;
        end
    end

    // Numerator: intercept term plus average times slope.
    assign w_prod = $signed({1'b0, r0_avg}) * r0_diff;
    assign w_num  = {{(NumW-ProdW){w_prod[ProdW-1]}}, w_prod}
                  + {{(NumW-ScaleW){r0_base[ScaleW-1]}}, r0_base};

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_ch  <= r0_ch;
            r1_avg <= r0_avg;
            r1_num <= w_num;
        end
    end

    // Split into sign and magnitude so the division truncates toward zero.
    assign w_mag = r1_num[NumW-1] ? MagW'(-r1_num) : r1_num[MagW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_ch  <= r1_ch;
            r2_avg <= r1_avg;
            r2_neg <= r1_num[NumW-1];
            r2_mag <= w_mag;
        end
    end

    // Divide by 4095 = 2^12 - 1 through its series; low by at most one.
    assign w_est = NumW'(r2_mag) + NumW'(r2_mag >> SampleW) + NumW'(r2_mag >> (2 * SampleW));

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_ch  <= r2_ch;
            r3_avg <= r2_avg;
            r3_neg <= r2_neg;
            r3_mag <= r2_mag;
            r3_qe  <= w_est[NumW-1:SampleW];
        end
    end

    // Remainder check fixes the estimate.
    assign w_rem = $signed({1'b0, r3_mag})
                 - $signed({r3_qe, {SampleW{1'b0}}})
                 + $signed(NumW'(r3_qe));
    assign w_q   = r3_qe + QuotW'(w_rem >= FullScale);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_ch  <= r3_ch;
            r4_avg <= r3_avg;
            r4_neg <= r3_neg;
            r4_q   <= w_q;
        end
    end

    // Restore the sign and saturate to 16 bits.
    always_comb begin
        if (r4_neg) begin
            if (r4_q > QuotW'(32768)) begin
                w_val = SatMin;
            end else begin
                w_val = CfgW'(-r4_q);
            end
        end else begin
            if (r4_q > QuotW'(32767)) begin
                w_val = SatMax;
            end else begin
                w_val = r4_q[CfgW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_ch  <= r4_ch;
            r5_avg <= r4_avg;
            r5_val <= w_val;
        end
    end

    assign o_valid        = r_valid[NumStages-1];
    assign o_out_channel  = r5_ch;
    assign o_average_raw  = r5_avg;
    assign o_scaled_value = r5_val;

`ifndef SYNTHESIS
    // The quotient estimate is never more than one below the true quotient.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[3] |-> ((w_rem >= 0) && (w_rem < 2 * FullScale)))
        else $error("division estimate out of its correction range");

    // A stalled estimate stage keeps its operands.
    a_est_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[3] && !w_en[3]) |=> (r_valid[3] && $stable(r3_mag) && $stable(r3_qe)))
        else $error("stalled estimate stage changed");

    // A transaction taken from the window stage enters the first stage.
    a_first_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_valid[0])
        else $error("transaction lost entering the scaling pipeline");
`endif

endmodule

@@ rtl/multichannel_moving_average_scaler.sv @@
// Channel   Direction  Handshake                Payload
// input     in         i_valid / o_ready        i_channel, i_raw_sample
// result    out        o_valid / i_ready        o_out_channel, o_average_raw, o_scaled_value
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction can be accepted every cycle unless all stages are full and i_ready is low;
// results pass the window stage and six scaling stages (average by reciprocal multiply,
// slope multiply, sign split, two-step division by 4095, saturation). Window history and
// sums update at accept, so samples of the same channel may follow back to back. Reset
// (synchronous, active low) clears the history, sums, pipeline valids and restores
// register defaults. Stages advance independently, so empty stages absorb new input
// while a result waits on i_ready.
module multichannel_moving_average_scaler #(
    parameter int CHANNELS  = 2,
    parameter int AVG_DEPTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_channel,
    input  logic [mmas_pkg::SampleW-1:0]      i_raw_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_out_channel,
    output logic [mmas_pkg::SampleW-1:0]      o_average_raw,
    output logic signed [mmas_pkg::CfgW-1:0]  o_scaled_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mmas_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [mmas_pkg::CfgW-1:0]         i_cfg_data
);
    import mmas_pkg::*;

    t_ch_cfg [NumCfgCh-1:0] w_ch_cfg;
    t_win_item              w_item;
    logic                   w_item_valid;
    logic                   w_item_ready;

    // Per-channel scaling registers.
    mmas_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ch_cfg    (w_ch_cfg)
    );

    // Sample history and running sums.
    mmas_window #(
        .CHANNELS  (CHANNELS),
        .AVG_DEPTH (AVG_DEPTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_channel    (i_channel),
        .i_raw_sample (i_raw_sample),
        .i_ch_cfg     (w_ch_cfg),
        .o_valid      (w_item_valid),
        .i_ready      (w_item_ready),
        .o_item       (w_item)
    );

    // Averaging and linear scaling pipeline.
    mmas_scale #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_item_valid),
        .o_ready        (w_item_ready),
        .i_item         (w_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_channel  (o_out_channel),
        .o_average_raw  (o_average_raw),
        .o_scaled_value (o_scaled_value)
    );

endmodule
